// File: src/dte_pkg.sv
`timescale 1ns / 1ps
// Package for the digest text encoder: format codes, character helpers and
// the group type passed from the encoder to the output serialiser.
// No dependencies.
package dte_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned CharW   = 8;
  localparam int unsigned MaxChars = 4;
  localparam int unsigned CountW  = 3;
  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;

  localparam logic [ModeW-1:0] MODE_HEX_LOWER = 3'd0;
  localparam logic [ModeW-1:0] MODE_HEX_UPPER = 3'd1;
  localparam logic [ModeW-1:0] MODE_B64_PAD   = 3'd2;
  localparam logic [ModeW-1:0] MODE_B64_URL   = 3'd3;
  localparam logic [ModeW-1:0] MODE_RAW       = 3'd4;

  localparam logic            REG_FORMAT_MODE = 1'b0;

  localparam logic [CharW-1:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CountW-1:0]              count;
    logic                           last;
  } dte_group_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [CharW-1:0] res;
    if (nib < 4'd10) begin
      res = 8'h30 + {4'h0, nib};
    end else begin
      res = (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
    end
    return res;
  endfunction

  function automatic logic [CharW-1:0] b64_char(input logic [5:0] v, input logic url);
    logic [CharW-1:0] res;
    if (v < 6'd26) begin
      res = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      res = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      res = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      res = url ? 8'h2D : 8'h2B;
    end else begin
      res = url ? 8'h5F : 8'h2F;
    end
    return res;
  endfunction

endpackage

// File: src/dte_encode.sv
`timescale 1ns / 1ps
// Encoder stage: turns one input byte into a group of up to four characters
// and keeps the partial base64 group. Depends on dte_pkg.
module dte_encode
  import dte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ModeW-1:0] mode_i,
  input  logic             clear_i,
  input  logic             fire_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output dte_group_t       group_o
);

  logic [15:0] held_bytes_q, held_bytes_d;
  logic [1:0]  held_count_q, held_count_d;
  logic [1:0]  cnt;
  logic [23:0] grp;
  logic        is_b64;
  logic        url;
  logic        pad;

  assign is_b64 = (mode_i == MODE_B64_PAD) || (mode_i == MODE_B64_URL);
  assign url    = (mode_i == MODE_B64_URL);
  assign pad    = (mode_i == MODE_B64_PAD);
  assign cnt    = (held_count_q == 2'd3) ? 2'd0 : held_count_q;

  always_comb begin
    case (cnt)
      2'd2:    grp = {held_bytes_q, byte_i};
      2'd1:    grp = {held_bytes_q[15:8], byte_i, 8'h00};
      default: grp = {byte_i, 16'h0000};
    endcase
  end

  always_comb begin
    group_o.chars = '0;
    group_o.count = '0;
    group_o.last  = last_i;
    held_bytes_d  = held_bytes_q;
    held_count_d  = held_count_q;
    case (mode_i)
      MODE_HEX_LOWER, MODE_HEX_UPPER: begin
        group_o.chars[0] = hex_char(byte_i[7:4], mode_i == MODE_HEX_UPPER);
        group_o.chars[1] = hex_char(byte_i[3:0], mode_i == MODE_HEX_UPPER);
        group_o.count    = 3'd2;
      end
      MODE_B64_PAD, MODE_B64_URL: begin
        group_o.chars[0] = b64_char(grp[23:18], url);
        group_o.chars[1] = b64_char(grp[17:12], url);
        group_o.chars[2] = b64_char(grp[11:6], url);
        group_o.chars[3] = b64_char(grp[5:0], url);
        if (cnt == 2'd2) begin
          group_o.count = 3'd4;
          held_bytes_d  = '0;
          held_count_d  = '0;
        end else if (!last_i) begin
          group_o.count = 3'd0;
          held_bytes_d  = (cnt == 2'd0) ? {byte_i, 8'h00} : {held_bytes_q[15:8], byte_i};
          held_count_d  = cnt + 2'd1;
        end else begin
          if (cnt == 2'd0) begin
            group_o.chars[2] = PAD_CHAR;
          end
          group_o.chars[3] = PAD_CHAR;
          group_o.count    = pad ? 3'd4 : {1'b0, cnt} + 3'd2;
          held_bytes_d     = '0;
          held_count_d     = '0;
        end
      end
      default: begin
        group_o.chars[0] = byte_i;
        group_o.count    = 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes_q <= '0;
      held_count_q <= '0;
    end else if (clear_i) begin
      held_bytes_q <= '0;
      held_count_q <= '0;
    end else if (fire_i && is_b64) begin
      held_bytes_q <= held_bytes_d;
      held_count_q <= held_count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_count_q != 2'd3)
    else $error("partial group count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && is_b64 && !clear_i && last_i) |=> held_count_q == 2'd0)
    else $error("partial group kept after the final byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i |=> (held_count_q == 2'd0 && held_bytes_q == 16'h0000))
    else $error("partial group not dropped on a mode write");

endmodule

// File: src/dte_serial.sv
`timescale 1ns / 1ps
// Output serialiser: holds one encoded group in the result register and
// hands out one character per cycle while ready_i is high. Depends on dte_pkg.
module dte_serial
  import dte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  dte_group_t       group_i,
  output logic             can_load_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [CharW-1:0] char_o,
  output logic             last_o
);

  logic [MaxChars-1:0][CharW-1:0] chars_q;
  logic [CountW-1:0]              rem_q;
  logic [1:0]                     idx_q;
  logic                           last_q;
  logic                           out_fire;

  assign valid_o    = (rem_q != '0);
  assign out_fire   = valid_o && ready_i;
  assign can_load_o = (rem_q == '0) || ((rem_q == 3'd1) && ready_i);
  assign char_o     = chars_q[idx_q];
  assign last_o     = last_q && (rem_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else if (load_i) begin
      rem_q  <= group_i.count;
      idx_q  <= '0;
      last_q <= group_i.last;
    end else if (out_fire) begin
      rem_q <= rem_q - 3'd1;
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chars_q <= group_i.chars;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q <= 3'd4)
    else $error("character count above group size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, rem_q} + {2'b00, idx_q}) <= 4'd4)
    else $error("character index runs past the group");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((rem_q == 3'd0) || (rem_q == 3'd1 && out_fire)))
    else $error("group loaded over undelivered characters");

endmodule

// File: src/digest_text_encoder.sv
`timescale 1ns / 1ps
// Top level of the digest text encoder: APB format register, encoder stage
// and output serialiser. Depends on dte_pkg, dte_encode and dte_serial.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = in_byte[7:0], tlast = in_last
//  m_axis    out        tdata = out_char[7:0], tlast = out_last
//  apb       in/out     register 0 at byte address 0: format_mode[2:0]
//
// One character leaves per cycle while m_axis_tready is high, set by the
// single output register. A byte that only fills a base64 group still
// waits for the previous group to drain, and it leaves a gap in the output
// on top of the four characters. A byte is taken in the cycle the last
// character of the previous group leaves, so bytes flow back to back.
// Reset clears the mode and any partial base64 group. A stalled output
// holds the pending group and the input.
module digest_text_encoder
  import dte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // in_byte[7:0]
  input  logic             s_axis_tlast,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [CharW-1:0] m_axis_tdata,   // out_char[7:0]
  output logic             m_axis_tlast,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [ModeW-1:0] mode_q;
  logic             cfg_wr;
  logic             can_load;
  logic             in_fire;
  dte_group_t       group;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_FORMAT_MODE);
  assign prdata = (paddr[2] == REG_FORMAT_MODE) ? {{(DataW-ModeW){1'b0}}, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_HEX_LOWER;
    end else if (cfg_wr) begin
      mode_q <= pwdata[ModeW-1:0];
    end
  end

  assign s_axis_tready = can_load;
  assign in_fire       = s_axis_tvalid && can_load;

  dte_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mode_i  (mode_q),
    .clear_i (cfg_wr),
    .fire_i  (in_fire),
    .byte_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .group_o (group)
  );

  dte_serial u_serial (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_fire),
    .group_i    (group),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .char_o     (m_axis_tdata),
    .last_o     (m_axis_tlast)
  );

endmodule

// File: tb/dte_stream_checker.sv
`timescale 1ns / 1ps
// Checker for the digest text encoder. It follows format register writes and
// input items, predicts the encoded characters and compares each output item
// with them in order. Depends on dte_pkg.
module dte_stream_checker
  import dte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // in_byte[7:0]
  input  logic             s_axis_tlast,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [CharW-1:0] m_axis_tdata,   // out_char[7:0]
  input  logic             m_axis_tlast,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               chars_pending
);

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             fin;
  } text_char_t;

  localparam logic [16*8-1:0] HEX_LOWER_SYMS = "0123456789abcdef";
  localparam logic [16*8-1:0] HEX_UPPER_SYMS = "0123456789ABCDEF";
  localparam logic [64*8-1:0] B64_STD_SYMS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [64*8-1:0] B64_URL_SYMS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

  logic [ModeW-1:0] format_q;
  logic [15:0]      held_bytes;
  logic [1:0]       held_count;
  text_char_t       expected_chars[$];

  function automatic logic [CharW-1:0] hex_sym(input logic [3:0] nib, input logic upper);
    int unsigned pos;
    pos = (15 - int'(nib)) * 8;
    return upper ? HEX_UPPER_SYMS[pos +: 8] : HEX_LOWER_SYMS[pos +: 8];
  endfunction

  function automatic logic [CharW-1:0] b64_sym(input logic [5:0] v, input logic url);
    int unsigned pos;
    pos = (63 - int'(v)) * 8;
    return url ? B64_URL_SYMS[pos +: 8] : B64_STD_SYMS[pos +: 8];
  endfunction

  task automatic expect_char(input logic [CharW-1:0] ch, input logic fin);
    text_char_t c;
    c.ch  = ch;
    c.fin = fin;
    expected_chars.push_back(c);
  endtask

  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [23:0] grp;
    logic [1:0]  cnt;
    logic        url;
    logic        pad;
    url = (format_q == MODE_B64_URL);
    pad = (format_q == MODE_B64_PAD);
    cnt = (held_count == 2'd3) ? 2'd0 : held_count;
    if (format_q == MODE_HEX_LOWER || format_q == MODE_HEX_UPPER) begin
      expect_char(hex_sym(b[7:4], format_q == MODE_HEX_UPPER), 1'b0);
      expect_char(hex_sym(b[3:0], format_q == MODE_HEX_UPPER), fin);
    end else if (pad || url) begin
      if (cnt == 2'd2) begin
        grp = {held_bytes, b};
        expect_char(b64_sym(grp[23:18], url), 1'b0);
        expect_char(b64_sym(grp[17:12], url), 1'b0);
        expect_char(b64_sym(grp[11:6], url), 1'b0);
        expect_char(b64_sym(grp[5:0], url), fin);
        held_bytes = '0;
        held_count = '0;
      end else if (!fin) begin
        if (cnt == 2'd0) begin
          held_bytes = {b, 8'h00};
        end else begin
          held_bytes[7:0] = b;
        end
        held_count = cnt + 2'd1;
      end else begin
        if (cnt == 2'd0) begin
          grp = {b, 16'h0000};
          expect_char(b64_sym(grp[23:18], url), 1'b0);
          expect_char(b64_sym(grp[17:12], url), !pad);
          if (pad) begin
            expect_char(PAD_CHAR, 1'b0);
            expect_char(PAD_CHAR, 1'b1);
          end
        end else begin
          grp = {held_bytes[15:8], b, 8'h00};
          expect_char(b64_sym(grp[23:18], url), 1'b0);
          expect_char(b64_sym(grp[17:12], url), 1'b0);
          expect_char(b64_sym(grp[11:6], url), !pad);
          if (pad) begin
            expect_char(PAD_CHAR, 1'b1);
          end
        end
        held_bytes = '0;
        held_count = '0;
      end
    end else begin
      expect_char(b, fin);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      format_q   = MODE_HEX_LOWER;
      held_bytes = '0;
      held_count = '0;
      expected_chars.delete();
      fail_count = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %02h (tlast %0b) with nothing outstanding",
                 m_axis_tdata, m_axis_tlast);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata !== want.ch) begin
            $error("out_char: expected %02h, got %02h", want.ch, m_axis_tdata);
            fail_count++;
          end
          if (m_axis_tlast !== want.fin) begin
            $error("out_last: expected %0b, got %0b", want.fin, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
      end
      if (psel && penable && pwrite && pready && (paddr >> 2) == REG_FORMAT_MODE) begin
        format_q   = pwdata[ModeW-1:0];
        held_bytes = '0;
        held_count = '0;
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the digest text encoder testbench: clock, reset, APB writes and
// stream stimulus with random bursts and output stalls. Depends on dte_pkg,
// digest_text_encoder and dte_stream_checker.
module tb;
  import dte_pkg::*;

  typedef enum int unsigned {
    SINK_FREE,
    SINK_HALF,
    SINK_SPARSE,
    SINK_TOGGLE
  } sink_style_e;

  localparam logic [AddrW-1:0] FORMAT_ADDR   = {REG_FORMAT_MODE, 2'b00};
  localparam logic [AddrW-1:0] UNMAPPED_ADDR = 3'd4;
  localparam logic [ModeW-1:0] MODE_UNUSED_5 = 3'd5;
  localparam logic [ModeW-1:0] MODE_UNUSED_6 = 3'd6;
  localparam logic [ModeW-1:0] MODE_UNUSED_7 = 3'd7;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // in_byte[7:0]
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [CharW-1:0] m_axis_tdata;   // out_char[7:0]
  logic             m_axis_tlast;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  int               fail_count;
  int               chars_pending;
  int unsigned      hold_requests = 0;
  int unsigned      burst_left = 0;

  always #6 clk_i = ~clk_i;

  digest_text_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  dte_stream_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .chars_pending(chars_pending)
  );

  task automatic offer_byte(input logic [7:0] b, input logic fin);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic fin);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 8));
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    offer_byte(b, fin);
  endtask

  task automatic drain_outputs();
    pause_sender(1);
    while (chars_pending != 0) @(negedge clk_i);
  endtask

  // A byte held for a base64 group produces nothing, so allow the pipeline
  // time to absorb it before the register changes.
  task automatic quiesce();
    drain_outputs();
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_format(input logic [ModeW-1:0] m);
    quiesce();
    write_reg(FORMAT_ADDR, {29'($urandom()), m});
  endtask

  initial begin : sink_side
    int unsigned holds_seen;
    int unsigned left;
    sink_style_e style;
    holds_seen = 0;
    left = 0;
    style = SINK_FREE;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          style = sink_style_e'($urandom_range(0, 3));
          left = $urandom_range(16, 64);
        end
        left--;
        case (style)
          SINK_FREE:   m_axis_tready <= 1'b1;
          SINK_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:     m_axis_tready <= ~m_axis_tready;
        endcase
      end
    end
  end

  initial begin : run_limit
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned sent;
    int unsigned frames;
    int unsigned pick;
    logic        broken;
    logic        fin;
    logic [ModeW-1:0] m;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_format(MODE_HEX_LOWER);
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b1);
    feed_byte(8'hA5, 1'b1);
    set_format(MODE_HEX_UPPER);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'h9A, 1'b1);
    set_format(MODE_B64_PAD);
    feed_byte(8'h00, 1'b1);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'hFE, 1'b1);
    feed_byte(8'hFB, 1'b0);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'hBF, 1'b1);
    // A write to an unmapped address must leave the partial group intact.
    feed_byte(8'h41, 1'b0);
    quiesce();
    write_reg(UNMAPPED_ADDR, $urandom());
    feed_byte(8'h42, 1'b1);
    // Rewriting the format drops the byte already held.
    feed_byte(8'h7E, 1'b0);
    set_format(MODE_B64_PAD);
    feed_byte(8'h00, 1'b1);
    set_format(MODE_B64_URL);
    feed_byte(8'hFB, 1'b0);
    feed_byte(8'hFF, 1'b0);
    feed_byte(8'hBF, 1'b1);
    feed_byte(8'hFF, 1'b1);
    feed_byte(8'h12, 1'b0);
    feed_byte(8'h34, 1'b1);
    set_format(MODE_RAW);
    feed_byte(8'h00, 1'b0);
    feed_byte(8'hFF, 1'b1);
    set_format(MODE_UNUSED_5);
    feed_byte(8'h5A, 1'b1);
    set_format(MODE_UNUSED_6);
    feed_byte(8'hC3, 1'b0);
    set_format(MODE_UNUSED_7);
    feed_byte(8'h81, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 0) begin
        m = MODE_B64_PAD;
      end else if (ph == 1) begin
        m = MODE_HEX_UPPER;
      end else if (ph == 11) begin
        m = MODE_UNUSED_7;
      end else begin
        pick = $urandom_range(0, 11);
        m = (pick < 10) ? ModeW'(pick / 2) : ModeW'(5 + $urandom_range(0, 2));
      end
      set_format(m);
      // The output side holds off for a long stretch while bytes keep coming.
      if (ph == 1) begin
        hold_requests++;
      end
      sent = 0;
      frames = 0;
      while (sent < 28) begin
        len = $urandom_range(1, 10);
        broken = ($urandom_range(0, 9) == 0);
        for (int unsigned i = 0; i < len; i++) begin
          fin = broken ? 1'($urandom_range(0, 1)) : (i == len - 1);
          feed_byte(8'($urandom_range(0, 255)), fin);
          sent++;
        end
        frames++;
        if (ph == 6 && frames == 2) begin
          drain_outputs();
        end
      end
    end

    drain_outputs();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (chars_pending != 0) begin
        $error("%0d expected characters never arrived", chars_pending);
      end
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
